[hdl/a2l_pkg.sv]
// Shared types, constants and helper functions for the Annex B to
// length-prefixed NAL converter. No dependencies; every other file uses it.

package a2l_pkg;

   // Output address space and field widths
   localparam int unsigned ADDR_BITS = 24;
   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned KIND_W    = 2;
   localparam int unsigned ADDR_W    = 24;
   localparam int unsigned VALUE_W   = 32;
   localparam int unsigned COUNT_W   = 24;
   localparam int unsigned TOTAL_W   = 25;
   localparam int unsigned STATUS_W  = 2;
   localparam int unsigned CAP_W     = 25;
   localparam int unsigned LEN_W     = 25;
   localparam int unsigned SEEN_W    = 3;
   // Room for write_pointer + 4 + nal_length + zero_run without wrap
   localparam int unsigned SUM_W     = 27;
   localparam int unsigned SLOTS     = 4;
   localparam int unsigned SLOT_SEL_W = $clog2(SLOTS);

   // Result kinds
   localparam logic [KIND_W-1:0] KIND_PAYLOAD  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ZERO_RUN = 2'd1;
   localparam logic [KIND_W-1:0] KIND_LENGTH   = 2'd2;
   localparam logic [KIND_W-1:0] KIND_DONE     = 2'd3;

   // Unit done status
   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_START = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_SHORT    = 2'd3;

   // Result slot order within one item's bundle
   localparam int unsigned SLOT_ZERO   = 0;
   localparam int unsigned SLOT_BYTE   = 1;
   localparam int unsigned SLOT_LENGTH = 2;
   localparam int unsigned SLOT_DONE   = 3;

   // NAL header decode
   localparam logic [BYTE_W-1:0] NAL_TYPE_MASK = 8'h1F;
   localparam logic [4:0]        NAL_TYPE_SPS  = 5'd7;
   localparam logic [4:0]        NAL_TYPE_PPS  = 5'd8;
   localparam logic [4:0]        NAL_TYPE_AUD  = 5'd9;
   localparam logic [BYTE_W-1:0] START_CODE_END = 8'd1;

   localparam logic [CAP_W-1:0]   CAP_RESET  = 25'd16777216;
   localparam logic [LEN_W-1:0]   LEN_MAX    = '1;
   localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;
   localparam logic [SEEN_W-1:0]  SEEN_FULL  = 3'd4;
   localparam logic [COUNT_W-1:0] START_ZEROS = 24'd2;
   localparam logic [SUM_W-1:0]   LEN_WORD_BYTES = 27'd4;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              last_byte;
   } item_type;

   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [ADDR_W-1:0]   address;
      logic [VALUE_W-1:0]  write_value;
      logic [COUNT_W-1:0]  zero_count;
      logic [TOTAL_W-1:0]  total_bytes;
      logic [STATUS_W-1:0] status;
   } result_type;

   typedef struct packed {
      logic [SLOTS-1:0]             mask;
      result_type [SLOTS-1:0]       slots;
   } bundle_type;

   // Clip the programmed capacity to the addressable range
   function automatic logic [CAP_W-1:0] cap_clip(input logic [CAP_W-1:0] value);
      logic [33:0] wide;
      logic [33:0] limit;
      wide  = 34'(value);
      limit = 34'(1) << ADDR_BITS;
      if (wide > limit) begin
         return CAP_W'(limit);
      end
      return value;
   endfunction

   // Saturate a running length or pointer to its register width
   function automatic logic [LEN_W-1:0] sat_len(input logic [SUM_W-1:0] value);
      if (value > SUM_W'(LEN_MAX)) begin
         return LEN_MAX;
      end
      return LEN_W'(value);
   endfunction

endpackage

[hdl/a2l_req_if.sv]
// Input channel: one Annex B byte per beat with its end-of-unit mark.
// Depends on a2l_pkg for field widths.

interface a2l_req_if;
   logic                           valid;
   logic                           ready;
   logic [a2l_pkg::BYTE_W-1:0]     data_byte;
   logic                           last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

[hdl/a2l_rsp_if.sv]
// Result channel: one output buffer write or unit-done report per beat.
// Depends on a2l_pkg for field widths.

interface a2l_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [a2l_pkg::KIND_W-1:0]     kind;
   logic [a2l_pkg::ADDR_W-1:0]     address;
   logic [a2l_pkg::VALUE_W-1:0]    write_value;
   logic [a2l_pkg::COUNT_W-1:0]    zero_count;
   logic [a2l_pkg::TOTAL_W-1:0]    total_bytes;
   logic [a2l_pkg::STATUS_W-1:0]   status;
   logic                           last_result;

   modport source (output valid, output kind, output address, output write_value,
                   output zero_count, output total_bytes, output status,
                   output last_result, input ready);
   modport sink   (input valid, input kind, input address, input write_value,
                   input zero_count, input total_bytes, input status,
                   input last_result, output ready);
endinterface

[hdl/annexb_to_length_prefixed_nal_unit.sv]
// Annex B to length-prefixed NAL converter, top level.
// The first result of a byte is presented from the result register once the byte
// leaves the input register (input register, then result register). One byte per
// cycle while each byte yields at most one result and the result port is ready;
// a byte with several results holds the input until the port takes its last one.
// Reset (synchronous) clears the unit state and sets the capacity to 2^24 bytes.

module annexb_to_length_prefixed_nal_unit (
   input  logic                        clock,
   input  logic                        reset,
   a2l_req_if.sink                     req_if,
   a2l_rsp_if.source                   rsp_if,
   input  logic                        csr_write_enable,
   input  logic [a2l_pkg::CAP_W-1:0]   csr_write_data
);

   logic                  item_valid;
   a2l_pkg::item_type     item;
   logic                  item_take;
   logic                  bundle_ready;
   a2l_pkg::bundle_type   bundle;

   // Input register
   a2l_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req        (req_if),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take)
   );

   // Parse and build the writes for one byte
   a2l_convert u_convert (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .item_valid       (item_valid),
      .item             (item),
      .bundle_ready     (bundle_ready),
      .item_take        (item_take),
      .bundle           (bundle)
   );

   // Result register and beat sequencer
   a2l_out_seq u_out_seq (
      .clock        (clock),
      .reset        (reset),
      .load         (item_take),
      .bundle       (bundle),
      .bundle_ready (bundle_ready),
      .rsp          (rsp_if)
   );

endmodule

[hdl/a2l_in_stage.sv]
// Input register for the converter: captures one byte beat and holds it
// until the conversion stage takes it. Depends on a2l_pkg and a2l_req_if.

module a2l_in_stage (
   input  logic                clock,
   input  logic                reset,
   a2l_req_if.sink             req,
   output logic                item_valid,
   output a2l_pkg::item_type   item,
   input  logic                item_take
);

   logic              valid_ff;
   logic              valid_in;
   a2l_pkg::item_type item_ff;
   a2l_pkg::item_type item_in;
   logic              accept;

   // Take a new beat when empty or when the held one leaves this cycle
   assign req.ready = !valid_ff || item_take;
   assign accept    = req.valid && req.ready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (accept) begin
         valid_in          = 1'b1;
         item_in.data_byte = req.data_byte;
         item_in.last_byte = req.last_byte;
      end else if (item_take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

[hdl/a2l_convert.sv]
// Conversion stage: holds the per-unit parse state and the capacity register,
// and turns one byte into a bundle of up to four results. Depends on a2l_pkg.

module a2l_convert (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_enable,
   input  logic [a2l_pkg::CAP_W-1:0]       csr_write_data,
   input  logic                            item_valid,
   input  a2l_pkg::item_type               item,
   input  logic                            bundle_ready,
   output logic                            item_take,
   output a2l_pkg::bundle_type             bundle
);

   // Parse state
   logic [a2l_pkg::SEEN_W-1:0]  bytes_seen_ff, bytes_seen_in;
   logic                        start_seen_ff, start_seen_in;
   logic [a2l_pkg::COUNT_W-1:0] zero_run_ff, zero_run_in;
   logic                        nal_open_ff, nal_open_in;
   logic                        nal_kept_ff, nal_kept_in;
   logic [a2l_pkg::LEN_W-1:0]   nal_length_ff, nal_length_in;
   logic [a2l_pkg::LEN_W-1:0]   write_pointer_ff, write_pointer_in;
   logic                        overflowed_ff, overflowed_in;
   logic [a2l_pkg::CAP_W-1:0]   capacity_ff, capacity_in;

   // Decode and datapath
   logic                        is_zero, is_start, is_other, is_byte, last;
   logic [a2l_pkg::COUNT_W-1:0] zero_inc, zero_flush;
   logic                        flush_en, flushed;
   logic [a2l_pkg::SUM_W-1:0]   base_addr, data_addr, cap_wide;
   logic                        open_f, kept_f, kept_b, type_ok;
   logic [4:0]                  nal_type;
   logic [a2l_pkg::LEN_W-1:0]   len_f, len_b, len_c, pointer_new;
   logic                        open_c, kept_c, close_do;
   logic                        zero_try, byte_try, zero_fit, byte_fit, len_fit;
   logic                        overflow_next, start_post;
   logic [a2l_pkg::SEEN_W-1:0]  seen_next;
   logic [a2l_pkg::TOTAL_W-1:0] total;
   logic [a2l_pkg::STATUS_W-1:0] status;

   assign item_take = item_valid && bundle_ready;
   assign last      = item.last_byte;

   // Classify the byte
   always_comb begin
      is_zero  = (item.data_byte == '0);
      is_start = (item.data_byte == a2l_pkg::START_CODE_END) &&
                 (zero_run_ff >= a2l_pkg::START_ZEROS);
      is_other = !is_zero && !is_start;
      is_byte  = is_other && start_seen_ff;
      zero_inc = (zero_run_ff == a2l_pkg::COUNT_MAX) ? zero_run_ff
                                                     : zero_run_ff + 1'b1;
      nal_type = 5'(item.data_byte & a2l_pkg::NAL_TYPE_MASK);
      type_ok  = !((nal_type == a2l_pkg::NAL_TYPE_SPS) ||
                   (nal_type == a2l_pkg::NAL_TYPE_PPS) ||
                   (nal_type == a2l_pkg::NAL_TYPE_AUD));
   end

   // Flush held zeros, place the payload byte, close the NAL
   always_comb begin
      flush_en   = start_seen_ff && (is_other || (is_zero && last));
      zero_flush = flush_en ? (is_zero ? zero_inc : zero_run_ff) : '0;
      flushed    = (zero_flush != '0);
      open_f     = nal_open_ff || flushed;
      kept_f     = nal_kept_ff || (!nal_open_ff && flushed);
      len_f      = a2l_pkg::sat_len(a2l_pkg::SUM_W'(nal_length_ff) +
                                    a2l_pkg::SUM_W'(zero_flush));
      kept_b     = open_f ? kept_f : type_ok;
      len_b      = a2l_pkg::sat_len(a2l_pkg::SUM_W'(len_f) + 1'b1);

      base_addr  = a2l_pkg::SUM_W'(write_pointer_ff) + a2l_pkg::LEN_WORD_BYTES +
                   a2l_pkg::SUM_W'(nal_length_ff);
      data_addr  = base_addr + a2l_pkg::SUM_W'(zero_flush);
      cap_wide   = a2l_pkg::SUM_W'(capacity_ff);
      zero_fit   = (data_addr <= cap_wide);
      byte_fit   = (data_addr < cap_wide);
      len_fit    = (a2l_pkg::SUM_W'(write_pointer_ff) + a2l_pkg::LEN_WORD_BYTES
                    <= cap_wide);
      zero_try   = flushed && kept_f;
      byte_try   = is_byte && kept_b;

      priority if (is_start) begin
         open_c = nal_open_ff;
         kept_c = nal_kept_ff;
         len_c  = nal_length_ff;
      end else if (is_byte) begin
         open_c = 1'b1;
         kept_c = kept_b;
         len_c  = len_b;
      end else begin
         open_c = open_f;
         kept_c = kept_f;
         len_c  = len_f;
      end
      close_do    = start_seen_ff && (is_start || last) && open_c && kept_c;
      pointer_new = close_do ? a2l_pkg::sat_len(data_addr +
                                                a2l_pkg::SUM_W'(is_byte))
                             : write_pointer_ff;

      overflow_next = overflowed_ff || (zero_try && !zero_fit) ||
                      (byte_try && !byte_fit) || (close_do && !len_fit);
      seen_next     = (bytes_seen_ff == a2l_pkg::SEEN_FULL) ? bytes_seen_ff
                                                            : bytes_seen_ff + 1'b1;
      start_post    = start_seen_ff || is_start;
   end

   // Unit done report
   always_comb begin
      total = '0;
      priority if (seen_next < a2l_pkg::SEEN_FULL) begin
         status = a2l_pkg::STATUS_SHORT;
      end else if (!start_post) begin
         status = a2l_pkg::STATUS_NO_START;
      end else if (overflow_next) begin
         status = a2l_pkg::STATUS_OVERFLOW;
      end else begin
         status = a2l_pkg::STATUS_OK;
         total  = pointer_new;
      end
   end

   // Assemble the bundle of writes in output order
   always_comb begin
      bundle = '0;
      bundle.mask[a2l_pkg::SLOT_ZERO]               = zero_try && zero_fit;
      bundle.slots[a2l_pkg::SLOT_ZERO].kind         = a2l_pkg::KIND_ZERO_RUN;
      bundle.slots[a2l_pkg::SLOT_ZERO].address      = a2l_pkg::ADDR_W'(base_addr);
      bundle.slots[a2l_pkg::SLOT_ZERO].zero_count   = zero_flush;

      bundle.mask[a2l_pkg::SLOT_BYTE]               = byte_try && byte_fit;
      bundle.slots[a2l_pkg::SLOT_BYTE].kind         = a2l_pkg::KIND_PAYLOAD;
      bundle.slots[a2l_pkg::SLOT_BYTE].address      = a2l_pkg::ADDR_W'(data_addr);
      bundle.slots[a2l_pkg::SLOT_BYTE].write_value  = a2l_pkg::VALUE_W'(item.data_byte);

      bundle.mask[a2l_pkg::SLOT_LENGTH]             = close_do && len_fit;
      bundle.slots[a2l_pkg::SLOT_LENGTH].kind       = a2l_pkg::KIND_LENGTH;
      bundle.slots[a2l_pkg::SLOT_LENGTH].address    = a2l_pkg::ADDR_W'(write_pointer_ff);
      bundle.slots[a2l_pkg::SLOT_LENGTH].write_value = a2l_pkg::VALUE_W'(len_c);

      bundle.mask[a2l_pkg::SLOT_DONE]               = last;
      bundle.slots[a2l_pkg::SLOT_DONE].kind         = a2l_pkg::KIND_DONE;
      bundle.slots[a2l_pkg::SLOT_DONE].total_bytes  = total;
      bundle.slots[a2l_pkg::SLOT_DONE].status       = status;
   end

   // Advance the parse state; drop everything at the end of the unit
   always_comb begin
      bytes_seen_in    = bytes_seen_ff;
      start_seen_in    = start_seen_ff;
      zero_run_in      = zero_run_ff;
      nal_open_in      = nal_open_ff;
      nal_kept_in      = nal_kept_ff;
      nal_length_in    = nal_length_ff;
      write_pointer_in = write_pointer_ff;
      overflowed_in    = overflowed_ff;
      capacity_in      = csr_write_enable ? a2l_pkg::cap_clip(csr_write_data)
                                          : capacity_ff;
      if (item_take) begin
         if (last) begin
            bytes_seen_in    = '0;
            start_seen_in    = 1'b0;
            zero_run_in      = '0;
            nal_open_in      = 1'b0;
            nal_kept_in      = 1'b0;
            nal_length_in    = '0;
            write_pointer_in = '0;
            overflowed_in    = 1'b0;
         end else begin
            bytes_seen_in = seen_next;
            overflowed_in = overflow_next;
            priority if (is_start) begin
               start_seen_in    = 1'b1;
               zero_run_in      = '0;
               nal_open_in      = 1'b0;
               nal_kept_in      = 1'b0;
               nal_length_in    = '0;
               write_pointer_in = pointer_new;
            end else if (is_zero) begin
               zero_run_in = zero_inc;
            end else if (is_byte) begin
               zero_run_in   = '0;
               nal_open_in   = 1'b1;
               nal_kept_in   = kept_b;
               nal_length_in = len_b;
            end else begin
               zero_run_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_seen_ff    <= '0;
         start_seen_ff    <= 1'b0;
         zero_run_ff      <= '0;
         nal_open_ff      <= 1'b0;
         nal_kept_ff      <= 1'b0;
         nal_length_ff    <= '0;
         write_pointer_ff <= '0;
         overflowed_ff    <= 1'b0;
         capacity_ff      <= a2l_pkg::cap_clip(a2l_pkg::CAP_RESET);
      end else begin
         bytes_seen_ff    <= bytes_seen_in;
         start_seen_ff    <= start_seen_in;
         zero_run_ff      <= zero_run_in;
         nal_open_ff      <= nal_open_in;
         nal_kept_ff      <= nal_kept_in;
         nal_length_ff    <= nal_length_in;
         write_pointer_ff <= write_pointer_in;
         overflowed_ff    <= overflowed_in;
         capacity_ff      <= capacity_in;
      end
   end

endmodule

[hdl/a2l_out_seq.sv]
// Result register: holds one item's bundle of writes and hands them out one
// beat at a time, lowest slot first. Depends on a2l_pkg and a2l_rsp_if.

module a2l_out_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  a2l_pkg::bundle_type   bundle,
   output logic                  bundle_ready,
   a2l_rsp_if.source             rsp
);

   logic [a2l_pkg::SLOTS-1:0]             mask_ff, mask_in;
   a2l_pkg::result_type [a2l_pkg::SLOTS-1:0] slots_ff, slots_in;
   logic [a2l_pkg::SLOT_SEL_W-1:0]        sel;
   logic [a2l_pkg::SLOTS-1:0]             rest;
   logic                                  take;
   a2l_pkg::result_type                   cur;

   // Pick the earliest pending slot
   always_comb begin
      sel = '0;
      for (int i = a2l_pkg::SLOTS - 1; i >= 0; i--) begin
         if (mask_ff[i]) begin
            sel = a2l_pkg::SLOT_SEL_W'(i);
         end
      end
      rest = mask_ff & ~(a2l_pkg::SLOTS'(1) << sel);
      cur  = slots_ff[sel];
   end

   assign rsp.valid    = |mask_ff;
   assign take         = rsp.valid && rsp.ready;
   assign bundle_ready = (rest == '0) && (!rsp.valid || rsp.ready);

   // Load a fresh bundle or retire the beat just taken
   always_comb begin
      mask_in  = mask_ff;
      slots_in = slots_ff;
      if (load) begin
         mask_in  = bundle.mask;
         slots_in = bundle.slots;
      end else if (take) begin
         mask_in = rest;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else begin
         mask_ff <= mask_in;
      end
      slots_ff <= slots_in;
   end

   assign rsp.kind        = cur.kind;
   assign rsp.address     = cur.address;
   assign rsp.write_value = cur.write_value;
   assign rsp.zero_count  = cur.zero_count;
   assign rsp.total_bytes = cur.total_bytes;
   assign rsp.status      = cur.status;
   assign rsp.last_result = (rest == '0);

endmodule
